### src/ntc_tc_pkg.sv
// Shared types, codes and constants for the NTC table temperature converter.
package ntc_tc_pkg;

    // Table size default and the width used for index/count compares
    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int CMP_W               = 11;

    // Field widths
    localparam int OHMS_W   = 24;
    localparam int TEMP_W   = 16;
    localparam int STEP_W   = 16;
    localparam int COUNT_W  = 7;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = OHMS_W + STEP_W;
    localparam int QUO_W    = STEP_W;
    localparam int DIV_CNT_W = $clog2(QUO_W + 1);

    // Input word kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_CONVERT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_INTERP = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_COLD   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_HOT    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_RD  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NO_SEG = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_TEMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_CNT  = 2'd2;

    // Register reset values
    localparam logic [TEMP_W-1:0]  RST_START_TEMP = 16'd0;
    localparam logic [STEP_W-1:0]  RST_TEMP_STEP  = 16'd1280;
    localparam logic [COUNT_W-1:0] RST_TABLE_CNT  = 7'd64;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK0,
        S_CHKN,
        S_LDHI,
        S_SCAN,
        S_MULF,
        S_DIVS,
        S_DIVW,
        S_MULI,
        S_SUM,
        S_EMIT
    } t_state;

endpackage

### src/ntc_tc_mem.sv
// Resistance table memory: one write port, one registered read port.
module ntc_tc_mem #(
    parameter int TABLE_DEPTH = ntc_tc_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]       i_wr_addr,
    input  logic [ntc_tc_pkg::OHMS_W-1:0]        i_wr_data,
    input  logic [$clog2(TABLE_DEPTH)-1:0]       i_rd_addr,
    output logic [ntc_tc_pkg::OHMS_W-1:0]        o_rd_data
);

    logic [ntc_tc_pkg::OHMS_W-1:0] r_mem [TABLE_DEPTH];
    logic [ntc_tc_pkg::OHMS_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/ntc_tc_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit QUO_W bits.
module ntc_tc_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ntc_tc_pkg::PROD_W-1:0]    i_dividend,
    input  logic [ntc_tc_pkg::OHMS_W-1:0]    i_divisor,
    output logic                             o_done,
    output logic [ntc_tc_pkg::QUO_W-1:0]     o_quotient
);

    logic [ntc_tc_pkg::OHMS_W-1:0]    r_rem,  n_rem;
    logic [ntc_tc_pkg::QUO_W-1:0]     r_quo,  n_quo;
    logic [ntc_tc_pkg::OHMS_W-1:0]    r_dsr,  n_dsr;
    logic [ntc_tc_pkg::DIV_CNT_W-1:0] r_cnt,  n_cnt;
    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [ntc_tc_pkg::OHMS_W:0]      w_trial;
    logic [ntc_tc_pkg::OHMS_W:0]      w_diff;

    // Partial remainder stays below the divisor, so 25 bits cover the trial
    assign w_trial = {r_rem, r_quo[ntc_tc_pkg::QUO_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_dividend[ntc_tc_pkg::PROD_W-1:ntc_tc_pkg::QUO_W];
            n_quo  = i_dividend[ntc_tc_pkg::QUO_W-1:0];
            n_dsr  = i_divisor;
            n_cnt  = ntc_tc_pkg::DIV_CNT_W'(ntc_tc_pkg::QUO_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[ntc_tc_pkg::OHMS_W]) begin
                n_rem = w_diff[ntc_tc_pkg::OHMS_W-1:0];
                n_quo = {r_quo[ntc_tc_pkg::QUO_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[ntc_tc_pkg::OHMS_W-1:0];
                n_quo = {r_quo[ntc_tc_pkg::QUO_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - ntc_tc_pkg::DIV_CNT_W'(1);
            if (r_cnt == ntc_tc_pkg::DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### src/ntc_tc_core.sv
// Sequencer and datapath: table scan, shared multiplier, sum and saturation.
module ntc_tc_core #(
    parameter int TABLE_DEPTH = ntc_tc_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // accepted input word
    input  logic                                i_acc,
    input  logic                                i_kind,
    input  logic [ntc_tc_pkg::INDEX_W-1:0]      i_entry_index,
    input  logic [ntc_tc_pkg::OHMS_W-1:0]       i_entry_ohms,
    input  logic [ntc_tc_pkg::OHMS_W-1:0]       i_sample_ohms,
    // configuration
    input  logic [ntc_tc_pkg::TEMP_W-1:0]       i_start_temp,
    input  logic [ntc_tc_pkg::STEP_W-1:0]       i_temp_step,
    input  logic [ntc_tc_pkg::COUNT_W-1:0]      i_table_count,
    // output register handshake
    input  logic                                i_out_free,
    output logic                                o_idle,
    output logic                                o_res_load,
    output logic [ntc_tc_pkg::TEMP_W-1:0]       o_res_temp,
    output logic [ntc_tc_pkg::STATUS_W-1:0]     o_res_status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = ntc_tc_pkg::PROD_W + 2;

    ntc_tc_pkg::t_state r_state, n_state;

    logic [ntc_tc_pkg::OHMS_W-1:0]   r_sample, n_sample;
    logic [ntc_tc_pkg::OHMS_W-1:0]   r_hi,     n_hi;
    logic [ntc_tc_pkg::OHMS_W-1:0]   r_width,  n_width;
    logic [ntc_tc_pkg::OHMS_W-1:0]   r_into,   n_into;
    logic [AW-1:0]                   r_idx,    n_idx;
    logic [ntc_tc_pkg::QUO_W-1:0]    r_frac,   n_frac;
    logic [ntc_tc_pkg::STATUS_W-1:0] r_status, n_status;
    logic [ntc_tc_pkg::TEMP_W-1:0]   r_res_temp, n_res_temp;
    logic [ntc_tc_pkg::PROD_W-1:0]   r_prod;

    logic [ntc_tc_pkg::OHMS_W-1:0]   w_mul_a;
    logic [AW-1:0]                   w_rd_addr;
    logic [ntc_tc_pkg::OHMS_W-1:0]   w_rd_data;
    logic                            w_wr_en;
    logic                            w_div_start;
    logic                            w_div_done;
    logic [ntc_tc_pkg::QUO_W-1:0]    w_div_quo;
    logic [ntc_tc_pkg::CMP_W-1:0]    w_cnt_ext;
    logic [CW-1:0]                   w_used;
    logic [CW-1:0]                   w_used_m1;
    logic [CW:0]                     w_idx_p2;
    logic signed [SW-1:0]            w_sum;
    logic [ntc_tc_pkg::TEMP_W-1:0]   w_sat;

    // Entries in use, clamped to 2..TABLE_DEPTH
    assign w_cnt_ext = ntc_tc_pkg::CMP_W'(i_table_count);
    always_comb begin
        if (w_cnt_ext < ntc_tc_pkg::CMP_W'(2)) begin
            w_used = CW'(2);
        end else if (w_cnt_ext > ntc_tc_pkg::CMP_W'(TABLE_DEPTH)) begin
            w_used = CW'(TABLE_DEPTH);
        end else begin
            w_used = CW'(w_cnt_ext);
        end
    end
    assign w_used_m1 = w_used - CW'(1);
    assign w_idx_p2  = (CW+1)'(r_idx) + (CW+1)'(2);

    assign w_wr_en = i_acc && (i_kind == ntc_tc_pkg::KIND_LOAD)
                     && (ntc_tc_pkg::CMP_W'(i_entry_index) < ntc_tc_pkg::CMP_W'(TABLE_DEPTH));

    ntc_tc_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_entry_index)),
        .i_wr_data (i_entry_ohms),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    ntc_tc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_width),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // Shared multiplier, operand picked by state, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= ntc_tc_pkg::PROD_W'(w_mul_a) * ntc_tc_pkg::PROD_W'(i_temp_step);
    end

    // start + product + fraction, saturated to 16 bits signed
    assign w_sum = SW'(signed'(i_start_temp)) + signed'(SW'(r_prod)) + signed'(SW'(r_frac));
    always_comb begin
        if (w_sum > SW'(32767)) begin
            w_sat = 16'h7FFF;
        end else if (w_sum < -SW'(32768)) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_sum[ntc_tc_pkg::TEMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntc_tc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_hi       <= n_hi;
        r_width    <= n_width;
        r_into     <= n_into;
        r_idx      <= n_idx;
        r_frac     <= n_frac;
        r_status   <= n_status;
        r_res_temp <= n_res_temp;
    end

    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_hi        = r_hi;
        n_width     = r_width;
        n_into      = r_into;
        n_idx       = r_idx;
        n_frac      = r_frac;
        n_status    = r_status;
        n_res_temp  = r_res_temp;
        w_rd_addr   = '0;
        w_mul_a     = r_into;
        w_div_start = 1'b0;
        o_res_load  = 1'b0;
        case (r_state)
            ntc_tc_pkg::S_IDLE: begin
                if (i_acc && (i_kind == ntc_tc_pkg::KIND_CONVERT)) begin
                    n_sample = i_sample_ohms;
                    if (i_sample_ohms == '0) begin
                        n_res_temp = '0;
                        n_status   = ntc_tc_pkg::STAT_NO_RD;
                        n_state    = ntc_tc_pkg::S_EMIT;
                    end else begin
                        n_state = ntc_tc_pkg::S_CHK0;
                    end
                end
            end
            ntc_tc_pkg::S_CHK0: begin
                w_rd_addr = AW'(w_used_m1);
                if (r_sample > w_rd_data) begin
                    n_res_temp = i_start_temp;
                    n_status   = ntc_tc_pkg::STAT_COLD;
                    n_state    = ntc_tc_pkg::S_EMIT;
                end else begin
                    n_state = ntc_tc_pkg::S_CHKN;
                end
            end
            ntc_tc_pkg::S_CHKN: begin
                w_mul_a = ntc_tc_pkg::OHMS_W'(w_used_m1);
                if (r_sample < w_rd_data) begin
                    n_frac   = '0;
                    n_status = ntc_tc_pkg::STAT_HOT;
                    n_state  = ntc_tc_pkg::S_SUM;
                end else begin
                    n_state = ntc_tc_pkg::S_LDHI;
                end
            end
            ntc_tc_pkg::S_LDHI: begin
                w_rd_addr = AW'(1);
                n_hi      = w_rd_data;
                n_idx     = '0;
                n_state   = ntc_tc_pkg::S_SCAN;
            end
            ntc_tc_pkg::S_SCAN: begin
                w_rd_addr = AW'(w_idx_p2);
                if ((r_hi >= r_sample) && (r_sample >= w_rd_data)) begin
                    n_width = r_hi - w_rd_data;
                    n_into  = r_hi - r_sample;
                    n_state = ntc_tc_pkg::S_MULF;
                end else if (w_idx_p2 < {1'b0, w_used}) begin
                    n_hi  = w_rd_data;
                    n_idx = r_idx + AW'(1);
                end else begin
                    n_res_temp = '0;
                    n_status   = ntc_tc_pkg::STAT_NO_SEG;
                    n_state    = ntc_tc_pkg::S_EMIT;
                end
            end
            ntc_tc_pkg::S_MULF: begin
                n_state = ntc_tc_pkg::S_DIVS;
            end
            ntc_tc_pkg::S_DIVS: begin
                n_status = ntc_tc_pkg::STAT_INTERP;
                if (r_width == '0) begin
                    n_frac  = '0;
                    n_state = ntc_tc_pkg::S_MULI;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = ntc_tc_pkg::S_DIVW;
                end
            end
            ntc_tc_pkg::S_DIVW: begin
                if (w_div_done) begin
                    n_frac  = w_div_quo;
                    n_state = ntc_tc_pkg::S_MULI;
                end
            end
            ntc_tc_pkg::S_MULI: begin
                w_mul_a = ntc_tc_pkg::OHMS_W'(r_idx);
                n_state = ntc_tc_pkg::S_SUM;
            end
            ntc_tc_pkg::S_SUM: begin
                n_res_temp = w_sat;
                n_state    = ntc_tc_pkg::S_EMIT;
            end
            ntc_tc_pkg::S_EMIT: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = ntc_tc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ntc_tc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_idle       = (r_state == ntc_tc_pkg::S_IDLE);
    assign o_res_temp   = r_res_temp;
    assign o_res_status = r_status;

endmodule

### src/ntc_table_temperature_convert.sv
// Top level of the NTC table temperature converter: ports, config registers, output register.
//
//  channel   dir  handshake                     word
//  --------  ---  ----------------------------  ---------------------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: entry_index, entry_ohms, sample_ohms
//                                                tuser: kind (0 load, 1 convert)
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: temperature_q8; tuser: status
//  cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// A load word is written to the table in the cycle it is taken; ready stays high.
// A convert: accept, end checks, a scan of the pairs in order (up to entries in use - 1,
// table_count held to 2..TABLE_DEPTH), then interpolation, the restoring divider giving
// 16 quotient bits, and the hand-over; a zero reading or one past either end skips ahead.
// Ready stays low throughout. A convert ending while the output register is full waits.
// Reset clears sequencer, config and output valid, not the table.
module ntc_table_temperature_convert #(
    parameter int TABLE_DEPTH = ntc_tc_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [5:0] entry_index, [29:6] entry_ohms,
                                        // [53:30] sample_ohms, [55:54] zero
    input  logic        s_axis_tuser,   // [0] kind
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] temperature_q8
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ntc_tc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [ntc_tc_pkg::TEMP_W-1:0]   r_start_temp;
    logic [ntc_tc_pkg::STEP_W-1:0]   r_temp_step;
    logic [ntc_tc_pkg::COUNT_W-1:0]  r_table_count;
    logic                            r_out_valid;
    logic [ntc_tc_pkg::TEMP_W-1:0]   r_out_temp;
    logic [ntc_tc_pkg::STATUS_W-1:0] r_out_status;

    logic                            w_acc;
    logic                            w_cfg_acc;
    logic                            w_idle;
    logic                            w_out_free;
    logic                            w_res_load;
    logic [ntc_tc_pkg::TEMP_W-1:0]   w_res_temp;
    logic [ntc_tc_pkg::STATUS_W-1:0] w_res_status;

    assign s_axis_tready = w_idle;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign w_cfg_acc     = i_cfg_valid && o_cfg_ready;
    // output register can take a result when empty or being drained this cycle
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // configuration registers; index 3 has no register and is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_temp  <= ntc_tc_pkg::RST_START_TEMP;
            r_temp_step   <= ntc_tc_pkg::RST_TEMP_STEP;
            r_table_count <= ntc_tc_pkg::RST_TABLE_CNT;
        end else if (w_cfg_acc) begin
            case (i_cfg_index)
                ntc_tc_pkg::REG_START_TEMP: r_start_temp  <= i_cfg_data;
                ntc_tc_pkg::REG_TEMP_STEP:  r_temp_step   <= i_cfg_data;
                ntc_tc_pkg::REG_TABLE_CNT:  r_table_count <= i_cfg_data[ntc_tc_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    ntc_tc_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (w_acc),
        .i_kind        (s_axis_tuser),
        .i_entry_index (s_axis_tdata[5:0]),
        .i_entry_ohms  (s_axis_tdata[29:6]),
        .i_sample_ohms (s_axis_tdata[53:30]),
        .i_start_temp  (r_start_temp),
        .i_temp_step   (r_temp_step),
        .i_table_count (r_table_count),
        .i_out_free    (w_out_free),
        .o_idle        (w_idle),
        .o_res_load    (w_res_load),
        .o_res_temp    (w_res_temp),
        .o_res_status  (w_res_status)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_out_temp   <= w_res_temp;
            r_out_status <= w_res_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_temp;
    assign m_axis_tuser  = r_out_status;

    // a convert of a zero reading goes straight to the result stage
    a_no_reading_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (s_axis_tuser == ntc_tc_pkg::KIND_CONVERT) && (s_axis_tdata[53:30] == '0))
        |=> !s_axis_tready && !w_res_load || (w_res_load && w_res_status == ntc_tc_pkg::STAT_NO_RD))
        else $error("zero reading did not go to result stage");

    // a result is only handed over while busy and the output register is free, never when idle
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |-> !w_idle && w_out_free)
        else $error("result loaded while idle or output full");

    // a load word never yields a result word
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (s_axis_tuser == ntc_tc_pkg::KIND_LOAD)) |=> s_axis_tready && !w_res_load)
        else $error("load word disturbed the sequencer");

    // output valid only rises when a result is loaded
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_res_load))
        else $error("output valid without a result");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the NTC table temperature converter: predicted readings vs results.
module tb;
    import ntc_tc_pkg::*;

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;
    // Index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // Settling time after the last reading; loads leave no result behind
    localparam int SETTLE_CYCLES = 100;

    typedef struct packed {
        logic [TEMP_W-1:0]   temp_q8;
        logic [STATUS_W-1:0] status;
    } t_reading;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [55:0]          s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;
    logic [2:0]           m_axis_tuser;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [15:0]          i_cfg_data    = '0;

    // Our own copy of the table and the registers, updated as words are taken
    logic [OHMS_W-1:0]  ohms_table [DEPTH];
    logic [TEMP_W-1:0]  start_q8 = RST_START_TEMP;
    logic [STEP_W-1:0]  step_q8  = RST_TEMP_STEP;
    logic [COUNT_W-1:0] count_q  = RST_TABLE_CNT;

    t_reading pending_readings [$];
    int       mismatches = 0;
    bit       no_idle    = 1'b0;   // both sides run flat out while set
    int       stall_left = 0;

    ntc_table_temperature_convert #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [TEMP_W-1:0] clip_q8(input longint t);
        if (t > 32767) t = 32767;
        else if (t < -32768) t = -32768;
        return t[TEMP_W-1:0];
    endfunction

    // table_count below 2 behaves as 2, above the depth as the depth
    function automatic int entries_in_use();
        if (count_q < 2) return 2;
        if (count_q > DEPTH) return DEPTH;
        return int'(count_q);
    endfunction

    // Note: with entry 0 >= r >= last entry some pair always brackets r, so the
    // no-segment status cannot be provoked; it is still predicted here.
    function automatic t_reading predict_reading(input logic [OHMS_W-1:0] r);
        t_reading res;
        int       n;
        longint   base, span, into;
        n           = entries_in_use();
        base        = longint'($signed(start_q8));
        res.temp_q8 = '0;
        res.status  = STAT_NO_SEG;
        if (r == 0) begin
            res.status = STAT_NO_RD;
        end else if (r > ohms_table[0]) begin
            res.temp_q8 = clip_q8(base);
            res.status  = STAT_COLD;
        end else if (r < ohms_table[n-1]) begin
            res.temp_q8 = clip_q8(base + longint'(n - 1) * longint'(step_q8));
            res.status  = STAT_HOT;
        end else begin
            // first pair with hi >= r >= lo wins; fraction truncates, flat pair gives 0
            for (int i = 0; i < n - 1; i++) begin
                if (ohms_table[i] >= r && r >= ohms_table[i+1]) begin
                    span = longint'(ohms_table[i]) - longint'(ohms_table[i+1]);
                    into = longint'(ohms_table[i]) - longint'(r);
                    res.temp_q8 = clip_q8(base + longint'(i) * longint'(step_q8) +
                                          ((span != 0) ? into * longint'(step_q8) / span : 0));
                    res.status  = STAT_INTERP;
                    return res;
                end
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- result side

    // Each result word draws its own stall before tready comes back
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            stall_left = no_idle ? 0 : $urandom_range(0, 15);
            if (stall_left != 0) m_axis_tready <= 1'b0;
        end else if (!m_axis_tready) begin
            if (stall_left > 1) begin
                stall_left--;
            end else begin
                stall_left = 0;
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected word: temperature_q8 %0d, status %0d",
                       $signed(m_axis_tdata), m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                if (m_axis_tdata !== want.temp_q8) begin
                    $error("temperature_q8: expected %0d, got %0d",
                           $signed(want.temp_q8), $signed(m_axis_tdata));
                    mismatches++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- input side

    // tvalid stays high between back-to-back words; only lowered for a gap
    task automatic send_word(input logic kind, input logic [INDEX_W-1:0] idx,
                             input logic [OHMS_W-1:0] entry, input logic [OHMS_W-1:0] sample);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, sample, entry, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == KIND_LOAD) ohms_table[idx] = entry;
        else pending_readings.push_back(predict_reading(sample));
    endtask

    // unused fields carry random bits as noise
    task automatic load_entry(input int idx, input logic [OHMS_W-1:0] value);
        send_word(KIND_LOAD, INDEX_W'(idx), value, OHMS_W'($urandom));
    endtask

    task automatic convert(input logic [OHMS_W-1:0] sample);
        send_word(KIND_CONVERT, INDEX_W'($urandom), OHMS_W'($urandom), sample);
    endtask

    // Drain: every predicted reading back, then let any last load settle
    task automatic wait_for_readings();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes every register plus the spare index; only called with the block idle
    task automatic configure(input logic [15:0] start_v, input logic [15:0] step_v,
                             input logic [15:0] count_v);
        logic [CFG_IDX_W-1:0] regs [4];
        logic [15:0]          values [4];
        regs   = '{REG_START_TEMP, REG_SPARE, REG_TEMP_STEP, REG_TABLE_CNT};
        values = '{start_v, 16'($urandom), step_v, count_v};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= values[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (regs[k])
                REG_START_TEMP: start_q8 = values[k];
                REG_TEMP_STEP:  step_q8  = values[k];
                REG_TABLE_CNT:  count_q  = values[k][COUNT_W-1:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Whole table, so any later table_count only reads written entries
    task automatic fill_table(input bit descending);
        logic [OHMS_W-1:0] level;
        level = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF
                                            : OHMS_W'($urandom_range(24'h800000, 24'hFFFFFF));
        for (int i = 0; i < DEPTH; i++) begin
            if (!descending) level = OHMS_W'($urandom);
            load_entry(i, level);
            // now and then a repeated entry gives a flat pair
            if (descending && $urandom_range(0, 7) != 0)
                level = level - OHMS_W'($urandom_range(0, level >> 3));
        end
    endtask

    task automatic random_word();
        int                n, i;
        logic [OHMS_W-1:0] hi, lo;
        n = entries_in_use();
        if ($urandom_range(0, 6) == 0) begin
            // table rewrite, mostly keeping the descending order
            i  = $urandom_range(0, DEPTH - 1);
            hi = (i == 0) ? 24'hFFFFFF : ohms_table[i-1];
            lo = (i == DEPTH - 1) ? 24'h000000 : ohms_table[i+1];
            if ($urandom_range(0, 3) == 0) load_entry(i, OHMS_W'($urandom));
            else load_entry(i, OHMS_W'($urandom_range(hi, lo)));
        end else begin
            i = $urandom_range(0, n - 2);
            case ($urandom_range(0, 9))
                0:       convert('0);
                1:       convert(24'hFFFFFF);
                2:       convert(OHMS_W'($urandom));
                3:       convert(ohms_table[0] + OHMS_W'($urandom_range(1, 255)));
                4:       convert(ohms_table[n-1] - OHMS_W'($urandom_range(1, 255)));
                5:       convert(ohms_table[i]);
                default: convert(OHMS_W'($urandom_range(ohms_table[i], ohms_table[i+1])));
            endcase
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        // 100 C start, 5 C per entry, four entries with a flat first pair
        configure(16'd25600, RST_TEMP_STEP, 16'd4);
        load_entry(0, 24'hA00000);
        load_entry(1, 24'hA00000);
        load_entry(2, 24'h300000);
        load_entry(3, 24'h000100);
        convert(24'h000000);    // no reading
        convert(24'hFFFFFF);    // cold clamp, top of field
        convert(24'hA00001);    // cold clamp, just above entry 0
        convert(24'hA00000);    // flat first pair: fraction 0
        convert(24'h680000);    // interpolated, middle segment
        convert(24'h300000);    // exactly on an entry
        convert(24'h000100);    // exactly on last entry in use
        convert(24'h0000FF);    // hot clamp, just below
        convert(24'h000001);    // hot clamp, smallest reading
        wait_for_readings();
        // top of range; upper data bits of table_count dropped, leaves 3
        configure(16'h7FFF, 16'hFFFF, 16'hFF83);
        convert(24'h900000);    // interpolated, saturates high
        convert(24'h200000);    // hot clamp, saturates high
        convert(24'hA00000);
        convert(24'hB00000);    // cold clamp at the top start
        wait_for_readings();
        // bottom of range, zero step; count 0 behaves as 2
        configure(16'h8000, 16'h0000, 16'h0000);
        convert(24'h000001);
        convert(24'hA00000);
        convert(24'hFFFFFF);
        wait_for_readings();
    endtask

    task automatic test_random_phases(input int phases, input int words_per_phase);
        for (int p = 0; p < phases; p++) begin
            wait_for_readings();
            case (p)
                0:       configure(16'h8000, 16'hFFFF, 16'h007F);  // count clipped to depth
                1:       configure(16'h7FFF, 16'h0000, 16'hFF80);  // count 0 behaves as 2
                default: configure(16'($urandom),
                                   ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 2560)),
                                   16'($urandom));
            endcase
            no_idle = (p == 2);
            if (p == 0 || $urandom_range(0, 1) != 0) fill_table($urandom_range(0, 4) != 0);
            for (int w = 0; w < words_per_phase; w++) begin
                random_word();
                // hold off now and then until every reading is back
                if ($urandom_range(0, 49) == 0) wait_for_readings();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phases(8, 70);
        wait_for_readings();
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
src/ntc_tc_pkg.sv
src/ntc_tc_mem.sv
src/ntc_tc_div.sv
src/ntc_tc_core.sv
src/ntc_table_temperature_convert.sv
tb/sv/tb.sv
